[rtl/page_table_map_walker_top_macros.svh]
// ----------------------------------------------------------------------------
// page_table_map_walker_top_macros.svh
// Assertion macros for the page table map walker.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_MAP_WALKER_TOP_MACROS_SVH
`define PAGE_TABLE_MAP_WALKER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define PTMW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PTMW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ptmw_pkg.sv]
// ----------------------------------------------------------------------------
// ptmw_pkg
// Types, constants and helpers shared by the page table map walker.
// ----------------------------------------------------------------------------
package ptmw_pkg;

    localparam int VA_W    = 48;
    localparam int ENTRY_W = 64;
    localparam int IDX_W   = 9;
    localparam int OFS_W   = 12;
    localparam int FU_W    = 7;

    localparam logic [ENTRY_W-1:0] TABLE_FLAGS = 64'h7;

    localparam logic ACT_MAP   = 1'b0;
    localparam logic ACT_UNMAP = 1'b1;

    localparam logic RES_OK  = 1'b0;
    localparam logic RES_ERR = 1'b1;

    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_LAST = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef struct packed {
        logic               action;
        logic [VA_W-1:0]    virt_addr;
        logic [ENTRY_W-1:0] phys_addr;
        logic [OFS_W-1:0]   attr_bits;
    } in_beat_t;

    typedef struct packed {
        logic               status;
        logic [ENTRY_W-1:0] leaf_value;
        logic [FU_W-1:0]    frames_used;
    } out_beat_t;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic rd;
        logic eval;
        logic off;
        logic chk;
        logic leaf_wr;
        logic finish;
        logic err;
    } ptmw_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic present;
        logic full;
        logic ptr_bad;
        logic last_lvl;
    } ptmw_stat_t;

    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0: begin
                idx = va[47:39];
            end
            2'd1: begin
                idx = va[38:30];
            end
            2'd2: begin
                idx = va[29:21];
            end
            default: begin
                idx = va[20:12];
            end
        endcase
        return idx;
    endfunction

endpackage

[rtl/ptmw_ctrl.sv]
// ----------------------------------------------------------------------------
// ptmw_ctrl
// Walk sequencer: clear pass, three table levels, leaf write, result hand-off.
// ----------------------------------------------------------------------------
module ptmw_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  ptmw_pkg::ptmw_stat_t  stat,
    output ptmw_pkg::ptmw_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_OFF,
        S_CHK,
        S_LEAF,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg & ~m_ready;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (stat.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (!stat.present && stat.full) begin
                    cmd.err    = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_OFF;
                end
            end
            S_OFF: begin
                cmd.off    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                cmd.chk = 1'b1;
                if (stat.ptr_bad) begin
                    cmd.err    = 1'b1;
                    state_next = S_DONE;
                end else if (stat.last_lvl) begin
                    state_next = S_LEAF;
                end else begin
                    state_next = S_RD;
                end
            end
            S_LEAF: begin
                cmd.leaf_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[rtl/ptmw_dp.sv]
// ----------------------------------------------------------------------------
// ptmw_dp
// Table store, bump allocator, pointer check and result register.
// ----------------------------------------------------------------------------
module ptmw_dp #(
    parameter int NUM_FRAMES     = 64,
    parameter int PHYS_ADDR_BITS = 36
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [47:0]            cfg_wdata,
    input  ptmw_pkg::in_beat_t     s_data,
    input  ptmw_pkg::ptmw_cmd_t    cmd,
    output ptmw_pkg::ptmw_stat_t   stat,
    output ptmw_pkg::out_beat_t    m_data
);

    localparam int FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int NFW   = $clog2(NUM_FRAMES + 1);
    localparam int AW    = FW + ptmw_pkg::IDX_W;
    localparam int DEPTH = NUM_FRAMES * 512;
    localparam int EW    = ptmw_pkg::ENTRY_W;
    localparam logic [EW-1:0] PTR_MASK =
        ((64'd1 << PHYS_ADDR_BITS) - 64'd1) << ptmw_pkg::OFS_W;
    localparam logic [AW-1:0]  CLR_LAST = AW'(DEPTH - 1);
    localparam logic [NFW-1:0] NF_MAX   = NFW'(NUM_FRAMES);

    logic [EW-1:0] mem [DEPTH];

    logic [47:0]         table_base_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [NFW-1:0]      next_free_reg;
    ptmw_pkg::in_beat_t  req_reg;
    logic [FW-1:0]       frame_reg;
    logic [1:0]          lvl_reg;
    logic [EW-1:0]       rd_data_reg;
    logic [EW-1:0]       ent_reg;
    logic [EW-1:0]       off_reg;
    logic [EW-1:0]       leaf_reg;
    logic                err_reg;
    ptmw_pkg::out_beat_t out_reg;

    logic [EW-1:0] frame0;
    logic [EW-1:0] nf_ext;
    logic [EW-1:0] new_ent;
    logic [EW-1:0] leaf_val;
    logic [AW-1:0] slot;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    assign frame0  = {16'b0, table_base_reg[47:12], 12'b0};
    assign nf_ext  = EW'(next_free_reg);
    assign new_ent = (frame0 + (nf_ext << ptmw_pkg::OFS_W)) | ptmw_pkg::TABLE_FLAGS;
    assign slot    = {frame_reg, ptmw_pkg::level_index(req_reg.virt_addr, lvl_reg)};
    assign leaf_val = (req_reg.action == ptmw_pkg::ACT_MAP) ?
        ({req_reg.phys_addr[63:12], 12'b0} | EW'(req_reg.attr_bits) | 64'd1) : '0;

    assign stat.clr_done = (clr_cnt_reg == CLR_LAST);
    assign stat.present  = rd_data_reg[0];
    assign stat.full     = (next_free_reg >= NF_MAX);
    assign stat.ptr_bad  = (off_reg[63:12] >= nf_ext[51:0]);
    assign stat.last_lvl = (lvl_reg == ptmw_pkg::LVL_LAST);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot;
        wr_data = leaf_val;
        if (cmd.clr_en) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end else if (cmd.eval && !rd_data_reg[0] && !stat.full) begin
            wr_en   = 1'b1;
            wr_data = new_ent;
        end else if (cmd.leaf_wr) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_base_reg <= '0;
            clr_cnt_reg    <= '0;
            next_free_reg  <= NFW'(1);
        end else begin
            if (cfg_we) begin
                table_base_reg <= cfg_wdata;
            end
            if (cmd.clr_en && !stat.clr_done) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.eval && !rd_data_reg[0] && !stat.full) begin
                next_free_reg <= next_free_reg + NFW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_data;
            frame_reg <= '0;
            lvl_reg   <= ptmw_pkg::LVL_TOP;
            leaf_reg  <= '0;
            err_reg   <= 1'b0;
        end
        if (cmd.err) begin
            err_reg <= 1'b1;
        end
        if (cmd.eval) begin
            ent_reg <= rd_data_reg[0] ? rd_data_reg : new_ent;
        end
        if (cmd.off) begin
            off_reg <= (ent_reg & PTR_MASK) - frame0;
        end
        if (cmd.chk && !stat.ptr_bad) begin
            frame_reg <= off_reg[ptmw_pkg::OFS_W +: FW];
            lvl_reg   <= lvl_reg + 2'd1;
        end
        if (cmd.leaf_wr) begin
            leaf_reg <= leaf_val;
        end
        if (cmd.finish) begin
            out_reg.status      <= err_reg ? ptmw_pkg::RES_ERR : ptmw_pkg::RES_OK;
            out_reg.leaf_value  <= err_reg ? '0 : leaf_reg;
            out_reg.frames_used <= nf_ext[ptmw_pkg::FU_W-1:0];
        end
    end

    assign m_data = out_reg;

endmodule

[rtl/page_table_map_walker_top.sv]
// ----------------------------------------------------------------------------
// page_table_map_walker_top
// Four-level page table map/unmap walker over a private store of table frames.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one map or unmap request per beat; the
//   m_valid/m_ready/m_data channel returns exactly one result beat per request.
//   cfg_we/cfg_wdata write table_base; write it only while the block is idle.
//   Walk: the request is loaded on accept; each of the three levels steps
//   through read, evaluate/allocate, offset and range check, then the leaf
//   write and the result load follow; an error at evaluate or range check
//   skips to the result load. s_ready stays low until the result is loaded.
//   Reset: the allocator restarts at frame one and the sequencer sweeps the
//   table store to zero, one entry per cycle, all NUM_FRAMES*512 entries
//   (32768 at the default), with s_ready low until the sweep ends.
//   Stall: a pending result sits in the output register while the next
//   request is taken and walked; the walker holds its finished result until
//   that register frees.
// ----------------------------------------------------------------------------
`include "page_table_map_walker_top_macros.svh"

module page_table_map_walker_top #(
    parameter int NUM_FRAMES     = 64,
    parameter int PHYS_ADDR_BITS = 36
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [47:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ptmw_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ptmw_pkg::out_beat_t  m_data
);

    ptmw_pkg::ptmw_cmd_t  cmd;
    ptmw_pkg::ptmw_stat_t stat;

    ptmw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptmw_dp #(
        .NUM_FRAMES     (NUM_FRAMES),
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

    `PTMW_ASSERT_NOW(a_one_op, aclk, aresetn, 1'b1, $onehot0({cmd.clr_en, cmd.load, cmd.rd, cmd.eval, cmd.off, cmd.chk, cmd.leaf_wr, cmd.finish}), "more than one datapath op")
    `PTMW_ASSERT_NOW(a_no_accept_in_clear, aclk, aresetn, cmd.clr_en, !s_ready, "request taken during clear sweep")
    `PTMW_ASSERT_NOW(a_load_on_accept, aclk, aresetn, cmd.load, s_valid && s_ready, "request loaded without accept")
    `PTMW_ASSERT_NEXT(a_finish_shows, aclk, aresetn, cmd.finish, m_valid, "result loaded but not presented")

endmodule
